### rtl/core/scsf_pkg.sv
// package for the soft circle smoothstep field core
// holds widths, register indexes, payload structs and sideband types
// used by every module of the core; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package scsf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int TAG_W     = 24;
    localparam int ETA_W     = FRAC_BITS + 1;
    localparam int POLY_W    = FRAC_BITS + 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 3'd4;

    localparam logic [ETA_W-1:0] ONE_Q = ETA_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [TAG_W-1:0]   node_tag;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] field_value;
        logic [TAG_W-1:0]   tag_out;
    } t_out_item;

    // sideband through the root pipeline
    typedef struct packed {
        logic             sat;
        logic [TAG_W-1:0] tag;
    } t_root_side;

    // sideband through the divider pipeline
    typedef struct packed {
        logic             in_circle;
        logic             beyond;
        logic [TAG_W-1:0] tag;
    } t_div_side;

endpackage
`default_nettype wire

### rtl/core/scsf_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on scsf_pkg for the sideband type
`timescale 1ns / 1ps
`default_nettype none
module scsf_isqrt (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [62:0]           i_radicand,
    input  wire scsf_pkg::t_root_side  i_side,
    output logic                       o_valid,
    output logic [31:0]                o_root,
    output scsf_pkg::t_root_side       o_side
);
    import scsf_pkg::*;

    localparam int NSTG = 32;

    logic             w_v    [0:NSTG];
    logic [34:0]      w_rem  [0:NSTG];
    logic [31:0]      w_root [0:NSTG];
    logic [63:0]      w_n    [0:NSTG];
    t_root_side       w_side [0:NSTG];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_n[0]    = {1'b0, i_radicand};
    assign w_side[0] = i_side;

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        logic        r_v;
        logic [34:0] r_rem;
        logic [31:0] r_root;
        logic [63:0] r_n;
        t_root_side  r_side;
        logic [34:0] rem_s;
        logic [34:0] trial;
        logic        ge;

        // bring down the next two radicand bits and try root*4+1
        assign rem_s = {w_rem[g][32:0], w_n[g][63:62]};
        assign trial = {1'b0, w_root[g], 2'b01};
        assign ge    = (rem_s >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= ge ? (rem_s - trial) : rem_s;
                r_root <= {w_root[g][30:0], ge};
                r_n    <= {w_n[g][61:0], 2'b00};
                r_side <= w_side[g];
            end
        end

        assign w_v[g+1]    = r_v;
        assign w_rem[g+1]  = r_rem;
        assign w_root[g+1] = r_root;
        assign w_n[g+1]    = r_n;
        assign w_side[g+1] = r_side;
    end

    assign o_valid = w_v[NSTG];
    assign o_root  = w_root[NSTG];
    assign o_side  = w_side[NSTG];

endmodule
`default_nettype wire

### rtl/core/scsf_div.sv
// pipelined restoring divider for the band weight, one quotient bit per stage
// quotient is (diff << FRAC_BITS) / divisor for diff <= divisor; uses scsf_pkg
`timescale 1ns / 1ps
`default_nettype none
module scsf_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [30:0]                  i_diff,
    input  wire logic [30:0]                  i_divisor,
    input  wire scsf_pkg::t_div_side          i_side,
    output logic                              o_valid,
    output logic [scsf_pkg::ETA_W-1:0]        o_quot,
    output scsf_pkg::t_div_side               o_side
);
    import scsf_pkg::*;

    localparam int NSTG = ETA_W;

    logic             w_v    [0:NSTG];
    logic [30:0]      w_rem  [0:NSTG];
    logic [ETA_W-1:0] w_q    [0:NSTG];
    t_div_side        w_side [0:NSTG];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = i_diff;
    assign w_q[0]    = '0;
    assign w_side[0] = i_side;

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        logic        r_v;
        logic [30:0] r_rem;
        logic [ETA_W-1:0] r_q;
        t_div_side   r_side;
        logic [31:0] rem_s;
        logic        ge;

        // the integer bit compares diff itself, later bits shift first
        if (g == 0) begin : g_first
            assign rem_s = {1'b0, w_rem[g]};
        end else begin : g_next
            assign rem_s = {w_rem[g], 1'b0};
        end
        assign ge = (rem_s >= {1'b0, i_divisor});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= ge ? 31'(rem_s - {1'b0, i_divisor}) : rem_s[30:0];
                r_q    <= {w_q[g][ETA_W-2:0], ge};
                r_side <= w_side[g];
            end
        end

        assign w_v[g+1]    = r_v;
        assign w_rem[g+1]  = r_rem;
        assign w_q[g+1]    = r_q;
        assign w_side[g+1] = r_side;
    end

    assign o_valid = w_v[NSTG];
    assign o_quot  = w_q[NSTG];
    assign o_side  = w_side[NSTG];

endmodule
`default_nettype wire

### rtl/core/soft_circle_smoothstep_field_core.sv
// top level of the soft circle smoothstep field core
// uses scsf_pkg, scsf_isqrt and scsf_div
// Each transaction in is one mesh node (x, y, tag) and each transaction out is
// amplitude * s(eta) with the tag unchanged, where eta is 1 inside the radius, falls
// linearly to 0 across the edge band and s is the quintic smoothstep, all Q16.16.
// The core is a fully pipelined datapath of 61 register stages: one transaction is
// taken every cycle while the pipeline is not held. Its depth is set by the
// 32-stage square root (one root bit per stage) and the 17-stage band divider (one
// quotient bit per stage). The whole pipeline advances together; it holds only
// when the output register is full and the receiver stalls, so o_stall follows
// i_stall in that case and nothing is lost or repeated. Configuration registers
// are written through a plain write port and should change only while idle.
`timescale 1ns / 1ps
`default_nettype none
module soft_circle_smoothstep_field_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire scsf_pkg::t_in_item                 i_data,
    // output channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output scsf_pkg::t_out_item                     o_data,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [scsf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [scsf_pkg::DATA_W-1:0]        i_cfg_wdata
);
    import scsf_pkg::*;

    // configuration registers
    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic [30:0]        r_radius;
    logic [30:0]        r_edge_width;
    logic signed [31:0] r_amplitude;

    // output slot
    logic      r_out_v;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_radius     <= '0;
            r_edge_width <= 31'(ONE_Q);
            r_amplitude  <= 32'(ONE_Q);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTER_X:   r_center_x   <= i_cfg_wdata;
                REG_CENTER_Y:   r_center_y   <= i_cfg_wdata;
                REG_RADIUS:     r_radius     <= i_cfg_wdata[30:0];
                REG_EDGE_WIDTH: r_edge_width <= i_cfg_wdata[30:0];
                REG_AMPLITUDE:  r_amplitude  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // global advance: move when the output slot is free or being taken
    logic en;
    assign en      = !r_out_v || !i_stall;
    assign o_stall = !en;

    // stage 1: absolute differences, saturation when either reaches 2^31
    logic [32:0] dx_w, dy_w, ax_w, ay_w;
    assign dx_w = {i_data.coord_x[31], i_data.coord_x} - {r_center_x[31], r_center_x};
    assign dy_w = {i_data.coord_y[31], i_data.coord_y} - {r_center_y[31], r_center_y};
    assign ax_w = dx_w[32] ? (33'd0 - dx_w) : dx_w;
    assign ay_w = dy_w[32] ? (33'd0 - dy_w) : dy_w;

    logic             r_s1_v, r_s1_sat;
    logic [30:0]      r_s1_ax, r_s1_ay;
    logic [TAG_W-1:0] r_s1_tag;

    // stage 2: squares
    logic             r_s2_v, r_s2_sat;
    logic [61:0]      r_s2_sx, r_s2_sy;
    logic [TAG_W-1:0] r_s2_tag;

    // stage 3: sum of squares
    logic             r_s3_v;
    logic [62:0]      r_s3_sum;
    t_root_side       r_s3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sat      <= (ax_w[32:31] != 2'b00) || (ay_w[32:31] != 2'b00);
            r_s1_ax       <= ax_w[30:0];
            r_s1_ay       <= ay_w[30:0];
            r_s1_tag      <= i_data.node_tag;
            r_s2_sat      <= r_s1_sat;
            r_s2_sx       <= 62'(r_s1_ax) * 62'(r_s1_ax);
            r_s2_sy       <= 62'(r_s1_ay) * 62'(r_s1_ay);
            r_s2_tag      <= r_s1_tag;
            r_s3_sum      <= 63'(r_s2_sx) + 63'(r_s2_sy);
            r_s3_side.sat <= r_s2_sat;
            r_s3_side.tag <= r_s2_tag;
        end
    end

    // distance: 32-stage root
    logic        sq_v;
    logic [31:0] sq_root;
    t_root_side  sq_side;

    scsf_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_s3_v),
        .i_radicand (r_s3_sum),
        .i_side     (r_s3_side),
        .o_valid    (sq_v),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    // stage 4: saturated distance; stage 5: compare with radius
    logic             r_s4_v;
    logic [30:0]      r_s4_dist;
    logic [TAG_W-1:0] r_s4_tag;
    logic             r_s5_v, r_s5_inside;
    logic [30:0]      r_s5_diff;
    logic [TAG_W-1:0] r_s5_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= sq_v;
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_dist   <= (sq_side.sat || sq_root[31]) ? 31'h7FFF_FFFF : sq_root[30:0];
            r_s4_tag    <= sq_side.tag;
            r_s5_inside <= (r_s4_dist <= r_radius);
            r_s5_diff   <= r_s4_dist - r_radius;
            r_s5_tag    <= r_s4_tag;
        end
    end

    // band weight divider
    t_div_side        dv_in_side;
    logic             dv_v;
    logic [ETA_W-1:0] dv_q;
    t_div_side        dv_side;

    assign dv_in_side.in_circle = r_s5_inside;
    assign dv_in_side.beyond    = (r_s5_diff > r_edge_width);
    assign dv_in_side.tag       = r_s5_tag;

    scsf_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_s5_v),
        .i_diff    (r_s5_diff),
        .i_divisor (r_edge_width),
        .i_side    (dv_in_side),
        .o_valid   (dv_v),
        .o_quot    (dv_q),
        .o_side    (dv_side)
    );

    // eta, powers, polynomial, clamp and amplitude scaling
    logic                     r_e0_v, r_e1_v, r_e2_v, r_e3_v, r_e4_v, r_e5_v;
    logic [ETA_W-1:0]         r_e0_eta, r_e1_eta, r_e1_e2, r_e2_e3, r_e4_w;
    logic [POLY_W-1:0]        r_e2_poly;
    logic [ETA_W+POLY_W-1:0]  r_e3_prod;
    logic signed [DATA_W+ETA_W:0] r_e5_prod;
    logic [TAG_W-1:0]         r_e0_tag, r_e1_tag, r_e2_tag, r_e3_tag, r_e4_tag, r_e5_tag;

    logic [ETA_W-1:0]          eta_w;
    logic [2*ETA_W-1:0]        sq_e2, sq_e3;
    logic [POLY_W-1:0]         poly_w;
    logic [ETA_W+POLY_W-FRAC_BITS-1:0] wsh;

    assign eta_w = dv_side.in_circle ? ONE_Q :
                   (dv_side.beyond || dv_q[ETA_W-1]) ? '0 : (ONE_Q - dv_q);
    assign sq_e2 = (2*ETA_W)'(r_e0_eta) * (2*ETA_W)'(r_e0_eta);
    assign sq_e3 = (2*ETA_W)'(r_e1_e2) * (2*ETA_W)'(r_e1_eta);
    // 6 e2 - 15 eta + 10, never negative for eta in [0, 1]
    assign poly_w = POLY_W'(6) * POLY_W'(r_e1_e2) + POLY_W'(10) * POLY_W'(ONE_Q)
                  - POLY_W'(15) * POLY_W'(r_e1_eta);
    assign wsh    = r_e3_prod[ETA_W+POLY_W-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_v <= 1'b0;
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
            r_e3_v <= 1'b0;
            r_e4_v <= 1'b0;
            r_e5_v <= 1'b0;
        end else if (en) begin
            r_e0_v <= dv_v;
            r_e1_v <= r_e0_v;
            r_e2_v <= r_e1_v;
            r_e3_v <= r_e2_v;
            r_e4_v <= r_e3_v;
            r_e5_v <= r_e4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e0_eta  <= eta_w;
            r_e0_tag  <= dv_side.tag;
            r_e1_eta  <= r_e0_eta;
            r_e1_e2   <= sq_e2[FRAC_BITS+ETA_W-1:FRAC_BITS];
            r_e1_tag  <= r_e0_tag;
            r_e2_e3   <= sq_e3[FRAC_BITS+ETA_W-1:FRAC_BITS];
            r_e2_poly <= poly_w;
            r_e2_tag  <= r_e1_tag;
            r_e3_prod <= (ETA_W+POLY_W)'(r_e2_e3) * (ETA_W+POLY_W)'(r_e2_poly);
            r_e3_tag  <= r_e2_tag;
            r_e4_w    <= (wsh > (ETA_W+POLY_W-FRAC_BITS)'(ONE_Q)) ? ONE_Q
                                                                 : wsh[ETA_W-1:0];
            r_e4_tag  <= r_e3_tag;
            r_e5_prod <= r_amplitude * $signed({1'b0, r_e4_w});
            r_e5_tag  <= r_e4_tag;
        end
    end

    // output register; arithmetic shift gives the floor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_e5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.field_value <= r_e5_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
            r_out.tag_out     <= r_e5_tag;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // a stall toward the source only comes from a full, stalled output slot
    a_stall_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_v && i_stall))
        else $error("input stalled without a held output");

    // an item leaving the root pipeline reaches the distance stage next cycle
    a_root_flow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && sq_v) |=> r_s4_v)
        else $error("item lost after root pipeline");

    // eta never exceeds one
    a_eta_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e0_v |-> (r_e0_eta <= ONE_Q))
        else $error("eta above one");

    // clamped weight never exceeds one
    a_w_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e4_v |-> (r_e4_w <= ONE_Q))
        else $error("weight above one");

endmodule
`default_nettype wire
